// ----- src/tehist_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tehist_pkg
// Shared types and constants for the tag emission histogram.
// ----------------------------------------------------------------------------
package tehist_pkg;

    localparam int SYMBOL_BITS = 16;
    localparam int COUNT_BITS  = 32;
    localparam int TAG_BITS    = 2;
    localparam int NUM_TAGS    = 1 << TAG_BITS;
    localparam int NUM_SYMBOLS = 1 << SYMBOL_BITS;
    localparam int CURSOR_BITS = SYMBOL_BITS + 1;

    // probabilities are Q0.16, one extra bit so that 1.0 fits
    localparam int FRAC_BITS  = 16;
    localparam int PROB_BITS  = FRAC_BITS + 1;
    localparam int PAIR_BITS  = COUNT_BITS + 1;
    localparam int TOTAL_BITS = COUNT_BITS + TAG_BITS;
    localparam int REM_BITS   = TOTAL_BITS + 1;
    localparam int STEP_BITS  = $clog2(PROB_BITS);

    localparam logic [SYMBOL_BITS-1:0] SPACE_CODE = SYMBOL_BITS'(16'h0020);
    localparam logic [CURSOR_BITS-1:0] CURSOR_END = CURSOR_BITS'(NUM_SYMBOLS);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};

    typedef enum logic {
        OP_COUNT = 1'b0,
        OP_EMIT  = 1'b1
    } op_t;

    typedef enum logic [TAG_BITS-1:0] {
        TAG_SINGLE = 2'd0,
        TAG_BEGIN  = 2'd1,
        TAG_MIDDLE = 2'd2,
        TAG_END    = 2'd3
    } tag_t;

    typedef logic [NUM_TAGS-1:0][COUNT_BITS-1:0] row_t;

    // handshake between the sequencer and the divider
    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] numer;
        logic [TOTAL_BITS-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [PROB_BITS-1:0] quot;
    } div_rsp_t;

endpackage

// ----- src/tag_emission_histogram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_emission_histogram
// Per-character tag counters with a forward scan that reports Q0.16
// emission probabilities for the next seen character.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  s_operation, s_symbol, s_tag
//  m_       out  m_valid / m_ready  m_out_symbol, m_prob_*, m_done_res
//
//  after reset a clearing pass writes zero to all 65536 counter rows,
//  one row a cycle; s_ready stays low until the clearing pass is done.
//  count request: row read, then saturating write-back; a space is not written.
//  emit request: accept, a scan over the symbols, then the pair sums and
//  the total, then 4 lanes in the shared restoring divider, then a finish;
//  an emit that finds nothing left skips the total and divider steps.
//  the result sits in an output register; new requests are taken while it
//  waits, and only a further emit result stalls until m_ready.
// ----------------------------------------------------------------------------
module tag_emission_histogram (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [tehist_pkg::SYMBOL_BITS-1:0] s_symbol,
    input  logic [tehist_pkg::TAG_BITS-1:0]    s_tag,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tehist_pkg::SYMBOL_BITS-1:0] m_out_symbol,
    output logic [tehist_pkg::PROB_BITS-1:0]   m_prob_single,
    output logic [tehist_pkg::PROB_BITS-1:0]   m_prob_begin,
    output logic [tehist_pkg::PROB_BITS-1:0]   m_prob_middle,
    output logic [tehist_pkg::PROB_BITS-1:0]   m_prob_end,
    output logic                               m_done_res
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CNT_WR,
        ST_SCAN,
        ST_SUM_PAIR,
        ST_SUM_ALL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [tehist_pkg::SYMBOL_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [tehist_pkg::CURSOR_BITS-1:0] cursor_reg,   cursor_next;
    logic                               pend_reg,     pend_next;
    logic [tehist_pkg::SYMBOL_BITS-1:0] pend_addr_reg, pend_addr_next;
    logic [tehist_pkg::SYMBOL_BITS-1:0] sym_reg,      sym_next;
    logic [tehist_pkg::TAG_BITS-1:0]    tag_reg,      tag_next;
    logic [tehist_pkg::TAG_BITS-1:0]    lane_reg,     lane_next;
    logic                               fin_done_reg, fin_done_next;
    tehist_pkg::row_t                   row_reg,      row_next;
    logic [tehist_pkg::PAIR_BITS-1:0]   pair_lo_reg,  pair_lo_next;
    logic [tehist_pkg::PAIR_BITS-1:0]   pair_hi_reg,  pair_hi_next;
    logic [tehist_pkg::TOTAL_BITS-1:0]  total_reg,    total_next;
    logic [tehist_pkg::PROB_BITS-1:0]   prob_reg  [tehist_pkg::NUM_TAGS];
    logic [tehist_pkg::PROB_BITS-1:0]   prob_next [tehist_pkg::NUM_TAGS];

    logic                               m_valid_reg,  m_valid_next;
    logic [tehist_pkg::SYMBOL_BITS-1:0] m_sym_reg,    m_sym_next;
    logic [tehist_pkg::PROB_BITS-1:0]   m_prob_reg  [tehist_pkg::NUM_TAGS];
    logic [tehist_pkg::PROB_BITS-1:0]   m_prob_next [tehist_pkg::NUM_TAGS];
    logic                               m_done_reg,   m_done_next;

    // counter table, one row of four counters per symbol
    tehist_pkg::row_t                   mem [tehist_pkg::NUM_SYMBOLS];
    tehist_pkg::row_t                   rd_data_reg;
    logic [tehist_pkg::SYMBOL_BITS-1:0] rd_addr;
    logic                               wr_en;
    logic [tehist_pkg::SYMBOL_BITS-1:0] wr_addr;
    tehist_pkg::row_t                   wr_data;

    tehist_pkg::div_req_t               div_req;
    tehist_pkg::div_rsp_t               div_rsp;

    logic                               row_seen;

    tehist_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign row_seen = |rd_data_reg;

    always_comb begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cursor_next    = cursor_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        sym_next       = sym_reg;
        tag_next       = tag_reg;
        lane_next      = lane_reg;
        fin_done_next  = fin_done_reg;
        row_next       = row_reg;
        pair_lo_next   = pair_lo_reg;
        pair_hi_next   = pair_hi_reg;
        total_next     = total_reg;
        prob_next      = prob_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_sym_next     = m_sym_reg;
        m_prob_next    = m_prob_reg;
        m_done_next    = m_done_reg;

        s_ready        = 1'b0;
        rd_addr        = cursor_reg[tehist_pkg::SYMBOL_BITS-1:0];
        wr_en          = 1'b0;
        wr_addr        = sym_reg;
        wr_data        = rd_data_reg;
        div_req.start  = 1'b0;
        div_req.numer  = row_reg[lane_reg];
        div_req.denom  = total_reg;

        case (state_reg)
            ST_CLEAR: begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = s_symbol;
                if (s_valid) begin
                    if (s_operation == tehist_pkg::OP_COUNT) begin
                        sym_next = s_symbol;
                        tag_next = s_tag;
                        // spaces are not counted
                        if (s_symbol != tehist_pkg::SPACE_CODE) begin
                            state_next = ST_CNT_WR;
                        end
                    end else begin
                        pend_next  = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CNT_WR: begin
                wr_en = 1'b1;
                if (rd_data_reg[tag_reg] != tehist_pkg::COUNT_MAX) begin
                    wr_data[tag_reg] = rd_data_reg[tag_reg] + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                // one read issued a cycle, the row checked in the cycle after
                if (pend_reg && row_seen) begin
                    row_next    = rd_data_reg;
                    sym_next    = pend_addr_reg;
                    cursor_next = tehist_pkg::CURSOR_BITS'(pend_addr_reg) + 1'b1;
                    pend_next   = 1'b0;
                    state_next  = ST_SUM_PAIR;
                end else if (cursor_reg != tehist_pkg::CURSOR_END) begin
                    pend_next      = 1'b1;
                    pend_addr_next = cursor_reg[tehist_pkg::SYMBOL_BITS-1:0];
                    cursor_next    = cursor_reg + 1'b1;
                end else begin
                    pend_next     = 1'b0;
                    fin_done_next = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_SUM_PAIR: begin
                pair_lo_next = tehist_pkg::PAIR_BITS'(row_reg[tehist_pkg::TAG_SINGLE])
                             + tehist_pkg::PAIR_BITS'(row_reg[tehist_pkg::TAG_BEGIN]);
                pair_hi_next = tehist_pkg::PAIR_BITS'(row_reg[tehist_pkg::TAG_MIDDLE])
                             + tehist_pkg::PAIR_BITS'(row_reg[tehist_pkg::TAG_END]);
                state_next   = ST_SUM_ALL;
            end
            ST_SUM_ALL: begin
                total_next = tehist_pkg::TOTAL_BITS'(pair_lo_reg)
                           + tehist_pkg::TOTAL_BITS'(pair_hi_reg);
                lane_next  = '0;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    prob_next[lane_reg] = div_rsp.quot;
                    if (&lane_reg) begin
                        fin_done_next = 1'b0;
                        state_next    = ST_FINISH;
                    end else begin
                        lane_next  = lane_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_FINISH: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_done_next  = fin_done_reg;
                    m_sym_next   = fin_done_reg ? '0 : sym_reg;
                    for (int k = 0; k < tehist_pkg::NUM_TAGS; k++) begin
                        m_prob_next[k] = fin_done_reg ? '0 : prob_reg[k];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cursor_reg   <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cursor_reg   <= cursor_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
        pend_addr_reg <= pend_addr_next;
        sym_reg       <= sym_next;
        tag_reg       <= tag_next;
        lane_reg      <= lane_next;
        fin_done_reg  <= fin_done_next;
        row_reg       <= row_next;
        pair_lo_reg   <= pair_lo_next;
        pair_hi_reg   <= pair_hi_next;
        total_reg     <= total_next;
        prob_reg      <= prob_next;
        m_sym_reg     <= m_sym_next;
        m_prob_reg    <= m_prob_next;
        m_done_reg    <= m_done_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_symbol  = m_sym_reg;
    assign m_prob_single = m_prob_reg[tehist_pkg::TAG_SINGLE];
    assign m_prob_begin  = m_prob_reg[tehist_pkg::TAG_BEGIN];
    assign m_prob_middle = m_prob_reg[tehist_pkg::TAG_MIDDLE];
    assign m_prob_end    = m_prob_reg[tehist_pkg::TAG_END];
    assign m_done_res    = m_done_reg;

endmodule

// ----- src/tehist_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tehist_div
// Restoring divider: floor(numer * 2^16 / denom), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tehist_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tehist_pkg::div_req_t req,
    output tehist_pkg::div_rsp_t rsp
);

    logic                                busy_reg,  busy_next;
    logic                                done_reg,  done_next;
    logic [tehist_pkg::STEP_BITS-1:0]    step_reg,  step_next;
    logic [tehist_pkg::REM_BITS-1:0]     rem_reg,   rem_next;
    logic [tehist_pkg::TOTAL_BITS-1:0]   denom_reg, denom_next;
    logic [tehist_pkg::PROB_BITS-1:0]    quot_reg,  quot_next;

    logic [tehist_pkg::REM_BITS-1:0]     denom_ext;
    logic [tehist_pkg::REM_BITS-1:0]     rem_kept;
    logic                                ge;

    assign denom_ext = tehist_pkg::REM_BITS'(denom_reg);
    assign ge        = (rem_reg >= denom_ext);
    assign rem_kept  = ge ? (rem_reg - denom_ext) : rem_reg;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        rem_next   = rem_reg;
        denom_next = denom_reg;
        quot_next  = quot_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            step_next  = '0;
            rem_next   = tehist_pkg::REM_BITS'(req.numer);
            denom_next = req.denom;
            quot_next  = '0;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the shift cannot overflow
            quot_next = {quot_reg[tehist_pkg::PROB_BITS-2:0], ge};
            rem_next  = {rem_kept[tehist_pkg::REM_BITS-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == tehist_pkg::STEP_BITS'(tehist_pkg::PROB_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg   <= rem_next;
        denom_reg <= denom_next;
        quot_reg  <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
